### hw/rtl/srfpll_pkg.sv
package srfpll_pkg;

    localparam int V_W     = 32;
    localparam int FREQ_W  = 40;
    localparam int XY_W    = 42;
    localparam int Z_W     = 33;
    localparam int MA_W    = 35;
    localparam int MB_W    = 33;
    localparam int PROD_W  = 68;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int OFF_W   = 12;
    localparam int GAIN_W  = 24;
    localparam int ROT_STEPS = 24;
    localparam int ROT_IDX_W = 5;
    localparam int OUT_W   = 200;

    localparam logic signed [MB_W-1:0] INV3_Q30     = 33'sd357913941;
    localparam logic signed [MB_W-1:0] INVSQRT3_Q30 = 33'sd619925131;
    localparam logic signed [MB_W-1:0] INVK_Q30     = 33'sd652032874;

    localparam logic signed [FREQ_W-1:0] FREQ_RESET = 40'sd2748779069;

    localparam logic [OFF_W-1:0]  OFFSET_A_RESET = 12'd2117;
    localparam logic [OFF_W-1:0]  OFFSET_B_RESET = 12'd2090;
    localparam logic [OFF_W-1:0]  OFFSET_C_RESET = 12'd2102;
    localparam logic [GAIN_W-1:0] GAIN_A_RESET   = 24'd2913199;
    localparam logic [GAIN_W-1:0] GAIN_B_RESET   = 24'd2905378;
    localparam logic [GAIN_W-1:0] GAIN_C_RESET   = 24'd2940244;
    localparam logic signed [V_W-1:0] COEF_NOW_RESET  = 32'sd4844136;
    localparam logic signed [V_W-1:0] COEF_PREV_RESET = -32'sd4839830;

    localparam logic signed [PROD_W-1:0] S32_MAX = 68'sd2147483647;
    localparam logic signed [PROD_W-1:0] S32_MIN = -68'sd2147483648;
    localparam logic signed [PROD_W-1:0] S40_MAX = 68'sd549755813887;
    localparam logic signed [PROD_W-1:0] S40_MIN = -68'sd549755813888;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_A  = 8'd0,
        CFG_OFFSET_B  = 8'd1,
        CFG_OFFSET_C  = 8'd2,
        CFG_GAIN_A    = 8'd3,
        CFG_GAIN_B    = 8'd4,
        CFG_GAIN_C    = 8'd5,
        CFG_COEF_NOW  = 8'd6,
        CFG_COEF_PREV = 8'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_A, OP_B, OP_C, OP_ALPHA, OP_BETA, OP_ZERO, OP_X, OP_Y,
        OP_PI_NOW, OP_PI_PREV
    } mul_op_t;

    typedef struct packed {
        logic                 load;
        logic                 mul_en;
        logic                 wb_en;
        mul_op_t              op;
        logic                 fold;
        logic                 rot_en;
        logic [ROT_IDX_W-1:0] rot_idx;
        logic                 vq_en;
        logic                 fin;
    } cmd_t;

    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] p,
        input int unsigned              n
    );
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) << (n - 1);
        return (p + half) >>> n;
    endfunction

    function automatic logic signed [V_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > S32_MAX)
            return V_W'(S32_MAX);
        else if (v < S32_MIN)
            return V_W'(S32_MIN);
        return v[V_W-1:0];
    endfunction

    function automatic logic signed [FREQ_W-1:0] sat40(input logic signed [PROD_W-1:0] v);
        if (v > S40_MAX)
            return FREQ_W'(S40_MAX);
        else if (v < S40_MIN)
            return FREQ_W'(S40_MIN);
        return v[FREQ_W-1:0];
    endfunction

    // arctan(2^-i) in 2^-32 turns
    function automatic logic signed [Z_W-1:0] atan_turn(input logic [ROT_IDX_W-1:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            5'd0:  r = 33'sd536870912;
            5'd1:  r = 33'sd316933406;
            5'd2:  r = 33'sd167458907;
            5'd3:  r = 33'sd85004756;
            5'd4:  r = 33'sd42667331;
            5'd5:  r = 33'sd21354465;
            5'd6:  r = 33'sd10679838;
            5'd7:  r = 33'sd5340245;
            5'd8:  r = 33'sd2670163;
            5'd9:  r = 33'sd1335087;
            5'd10: r = 33'sd667544;
            5'd11: r = 33'sd333772;
            5'd12: r = 33'sd166886;
            5'd13: r = 33'sd83443;
            5'd14: r = 33'sd41722;
            5'd15: r = 33'sd20861;
            5'd16: r = 33'sd10430;
            5'd17: r = 33'sd5215;
            5'd18: r = 33'sd2608;
            5'd19: r = 33'sd1304;
            5'd20: r = 33'sd652;
            5'd21: r = 33'sd326;
            5'd22: r = 33'sd163;
            5'd23: r = 33'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/srfpll_ctrl.sv
module srfpll_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output srfpll_pkg::cmd_t   cmd
);
    import srfpll_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_WB, S_FOLD, S_ROT, S_VQ, S_FIN
    } state_t;

    state_t               state_reg, state_next;
    mul_op_t              op_reg, op_next;
    logic [ROT_IDX_W-1:0] rot_reg, rot_next;
    logic                 out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        rot_next       = rot_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                    op_next    = OP_A;
                end
            end
            S_MUL:
                state_next = S_WB;
            S_WB:
            begin
                if (op_reg == OP_Y)
                    state_next = S_FOLD;
                else if (op_reg == OP_PI_PREV)
                    state_next = S_FIN;
                else
                begin
                    op_next    = mul_op_t'(op_reg + 4'd1);
                    state_next = S_MUL;
                end
            end
            S_FOLD:
            begin
                rot_next   = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (rot_reg == ROT_IDX_W'(ROT_STEPS - 1))
                    state_next = S_VQ;
                else
                    rot_next = rot_reg + 1'b1;
            end
            S_VQ:
            begin
                op_next    = OP_PI_NOW;
                state_next = S_MUL;
            end
            S_FIN:
            begin
                // result register must be empty before the state is committed
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_A;
            rot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load    = (state_reg == S_IDLE) && in_valid;
        cmd.mul_en  = (state_reg == S_MUL);
        cmd.wb_en   = (state_reg == S_WB);
        cmd.op      = op_reg;
        cmd.fold    = (state_reg == S_FOLD);
        cmd.rot_en  = (state_reg == S_ROT);
        cmd.rot_idx = rot_reg;
        cmd.vq_en   = (state_reg == S_VQ);
        cmd.fin     = (state_reg == S_FIN) && !out_valid_reg;
    end

endmodule

### hw/rtl/srfpll_dp.sv
module srfpll_dp #(
    parameter int ADC_BITS   = 12,
    parameter int ANGLE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  srfpll_pkg::cmd_t                      cmd,
    input  logic [ADC_BITS-1:0]                   code_a,
    input  logic [ADC_BITS-1:0]                   code_b,
    input  logic [ADC_BITS-1:0]                   code_c,
    input  logic                                  cfg_we,
    input  logic [srfpll_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srfpll_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [31:0]                           grid_angle,
    output logic [31:0]                           lead_angle,
    output logic signed [srfpll_pkg::FREQ_W-1:0]  freq_step,
    output logic signed [srfpll_pkg::V_W-1:0]     v_direct,
    output logic signed [srfpll_pkg::V_W-1:0]     v_quadrature,
    output logic signed [srfpll_pkg::V_W-1:0]     v_zero
);
    import srfpll_pkg::*;

    localparam int ADV_SH  = 8 + 32 - ANGLE_BITS;
    localparam int LEAD_SH = 9 + 32 - ANGLE_BITS;

    // configuration
    logic [OFF_W-1:0]         off_a_reg, off_b_reg, off_c_reg;
    logic [GAIN_W-1:0]        gain_a_reg, gain_b_reg, gain_c_reg;
    logic signed [V_W-1:0]    coef_now_reg, coef_prev_reg;

    // loop state
    logic [ANGLE_BITS-1:0]    angle_reg;
    logic signed [FREQ_W-1:0] freq_reg;
    logic signed [V_W-1:0]    last_vq_reg;

    // working registers
    logic [ADC_BITS-1:0]      ca_reg, cb_reg, cc_reg;
    logic signed [V_W-1:0]    va_reg, vb_reg, vc_reg;
    logic signed [V_W-1:0]    alpha_reg, beta_reg, zero_reg;
    logic signed [XY_W-1:0]   x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [V_W-1:0]    vq_reg, vd_reg;
    logic signed [PROD_W-1:0] prod_reg, pi_reg;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MA_W-1:0]   va_x, vb_x, vc_x;
    logic [31:0]              turn, turn_q;
    logic                     flip;
    logic signed [XY_W-1:0]   xs, ys;
    logic signed [PROD_W-1:0] freq_sum;
    logic signed [FREQ_W-1:0] freq_new;
    logic [ANGLE_BITS-1:0]    lead_new;

    function automatic logic signed [MA_W-1:0] code_diff(
        input logic [ADC_BITS-1:0] code,
        input logic [OFF_W-1:0]    off
    );
        return $signed({{(MA_W - ADC_BITS){1'b0}}, code})
             - $signed({{(MA_W - OFF_W){1'b0}}, off});
    endfunction

    assign va_x = MA_W'(va_reg);
    assign vb_x = MA_W'(vb_reg);
    assign vc_x = MA_W'(vc_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_A:
            begin
                mul_a = code_diff(ca_reg, off_a_reg);
                mul_b = $signed({{(MB_W - GAIN_W){1'b0}}, gain_a_reg});
            end
            OP_B:
            begin
                mul_a = code_diff(cb_reg, off_b_reg);
                mul_b = $signed({{(MB_W - GAIN_W){1'b0}}, gain_b_reg});
            end
            OP_C:
            begin
                mul_a = code_diff(cc_reg, off_c_reg);
                mul_b = $signed({{(MB_W - GAIN_W){1'b0}}, gain_c_reg});
            end
            OP_ALPHA:
            begin
                mul_a = (va_x <<< 1) - vb_x - vc_x;
                mul_b = INV3_Q30;
            end
            OP_BETA:
            begin
                mul_a = vb_x - vc_x;
                mul_b = INVSQRT3_Q30;
            end
            OP_ZERO:
            begin
                mul_a = va_x + vb_x + vc_x;
                mul_b = INV3_Q30;
            end
            OP_X:
            begin
                mul_a = MA_W'(alpha_reg);
                mul_b = INVK_Q30;
            end
            OP_Y:
            begin
                mul_a = MA_W'(beta_reg);
                mul_b = INVK_Q30;
            end
            OP_PI_NOW:
            begin
                mul_a = MA_W'(vq_reg);
                mul_b = MB_W'(coef_now_reg);
            end
            OP_PI_PREV:
            begin
                mul_a = MA_W'(last_vq_reg);
                mul_b = MB_W'(coef_prev_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // quadrant fold: second and third quadrants rotate by half a turn first
    always_comb
    begin
        turn   = 32'(angle_reg) << (32 - ANGLE_BITS);
        turn_q = turn + 32'h4000_0000;
        flip   = turn_q[31];
    end

    assign xs = x_reg >>> cmd.rot_idx;
    assign ys = y_reg >>> cmd.rot_idx;

    always_comb
    begin
        freq_sum = PROD_W'(freq_reg) + rnd_shift(pi_reg, 16);
        freq_new = sat40(freq_sum);
        lead_new = angle_reg + ANGLE_BITS'(freq_new >>> LEAD_SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_a_reg     <= OFFSET_A_RESET;
            off_b_reg     <= OFFSET_B_RESET;
            off_c_reg     <= OFFSET_C_RESET;
            gain_a_reg    <= GAIN_A_RESET;
            gain_b_reg    <= GAIN_B_RESET;
            gain_c_reg    <= GAIN_C_RESET;
            coef_now_reg  <= COEF_NOW_RESET;
            coef_prev_reg <= COEF_PREV_RESET;
            angle_reg     <= '0;
            freq_reg      <= FREQ_RESET;
            last_vq_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OFFSET_A:  off_a_reg     <= cfg_data[OFF_W-1:0];
                    CFG_OFFSET_B:  off_b_reg     <= cfg_data[OFF_W-1:0];
                    CFG_OFFSET_C:  off_c_reg     <= cfg_data[OFF_W-1:0];
                    CFG_GAIN_A:    gain_a_reg    <= cfg_data[GAIN_W-1:0];
                    CFG_GAIN_B:    gain_b_reg    <= cfg_data[GAIN_W-1:0];
                    CFG_GAIN_C:    gain_c_reg    <= cfg_data[GAIN_W-1:0];
                    CFG_COEF_NOW:  coef_now_reg  <= $signed(cfg_data[V_W-1:0]);
                    CFG_COEF_PREV: coef_prev_reg <= $signed(cfg_data[V_W-1:0]);
                    default:       ;
                endcase
            end
            if (cmd.load)
                angle_reg <= angle_reg + ANGLE_BITS'(freq_reg >>> ADV_SH);
            if (cmd.fin)
            begin
                freq_reg    <= freq_new;
                last_vq_reg <= vq_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ca_reg <= code_a;
            cb_reg <= code_b;
            cc_reg <= code_c;
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.wb_en)
        begin
            case (cmd.op)
                OP_A:       va_reg    <= sat32(rnd_shift(prod_reg, 8));
                OP_B:       vb_reg    <= sat32(rnd_shift(prod_reg, 8));
                OP_C:       vc_reg    <= sat32(rnd_shift(prod_reg, 8));
                OP_ALPHA:   alpha_reg <= sat32(rnd_shift(prod_reg, 30));
                OP_BETA:    beta_reg  <= sat32(rnd_shift(prod_reg, 30));
                OP_ZERO:    zero_reg  <= sat32(rnd_shift(prod_reg, 30));
                OP_X:       x_reg     <= XY_W'(rnd_shift(prod_reg, 22));
                OP_Y:       y_reg     <= XY_W'(rnd_shift(prod_reg, 22));
                OP_PI_NOW:  pi_reg    <= prod_reg;
                OP_PI_PREV: pi_reg    <= pi_reg + prod_reg;
                default:    ;
            endcase
        end
        if (cmd.fold)
        begin
            if (flip)
            begin
                x_reg <= -x_reg;
                y_reg <= -y_reg;
                z_reg <= Z_W'($signed(turn - 32'h8000_0000));
            end
            else
                z_reg <= Z_W'($signed(turn));
        end
        if (cmd.rot_en)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg - atan_turn(cmd.rot_idx);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg + atan_turn(cmd.rot_idx);
            end
        end
        if (cmd.vq_en)
        begin
            vq_reg <= sat32(rnd_shift(PROD_W'(x_reg), 8));
            vd_reg <= sat32(-rnd_shift(PROD_W'(y_reg), 8));
        end
        if (cmd.fin)
        begin
            grid_angle   <= 32'(angle_reg);
            lead_angle   <= 32'(lead_new);
            freq_step    <= freq_new;
            v_direct     <= vd_reg;
            v_quadrature <= vq_reg;
            v_zero       <= zero_reg;
        end
    end

endmodule

### hw/rtl/srf_pll_park_transform_top.sv
// Three-phase grid PLL with Park transform, one step per ADC sample word.
// Input stream (s_axis_*): one word carries the three raw voltage codes of a
// sample. Output stream (m_axis_*): one word per input word with the new
// angle, the half-step lead angle, the frequency word and vd, vq, v0.
// Configuration channel (cfg_*): index 0..7 selects offsets A..C, gains A..C,
// then the two PI weights; other indices are dropped. cfg_ready is always
// high; write only while no sample is in flight.
// Sequence: from acceptance to a valid result, a sample passes through ten
// products on one shared 35x33 multiplier, each a multiply then a write-back,
// plus 24 CORDIC iterations at one per cycle, plus the quadrant fold, the
// vq/vd rounding and the commit. The next sample is taken the cycle after
// the commit, so a word is only taken once the last one is committed, and
// the commit waits while the receiver has not taken the previous result.
// Stall: a result held in the output register blocks only the commit of the
// following sample; that sample is accepted and processed up to that point.
// Reset: asynchronous, active low; configuration registers return to their
// power-on values, angle to zero, frequency to nominal, previous vq to zero.
module srf_pll_park_transform_top #(
    parameter int ADC_BITS   = 12,
    parameter int ANGLE_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // code_a, code_b, code_c, zero padding
    input  logic [((3 * ADC_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // grid_angle, lead_angle, freq_step, v_direct, v_quadrature, v_zero
    output logic [srfpll_pkg::OUT_W-1:0]           m_axis_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [srfpll_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [srfpll_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import srfpll_pkg::*;

    cmd_t                     cmd;
    logic [31:0]              grid_angle, lead_angle;
    logic signed [FREQ_W-1:0] freq_step;
    logic signed [V_W-1:0]    v_direct, v_quadrature, v_zero;

    assign cfg_ready = 1'b1;

    srfpll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    srfpll_dp #(
        .ADC_BITS   (ADC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .code_a       (s_axis_tdata[ADC_BITS-1:0]),
        .code_b       (s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
        .code_c       (s_axis_tdata[3*ADC_BITS-1:2*ADC_BITS]),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .grid_angle   (grid_angle),
        .lead_angle   (lead_angle),
        .freq_step    (freq_step),
        .v_direct     (v_direct),
        .v_quadrature (v_quadrature),
        .v_zero       (v_zero)
    );

    assign m_axis_tdata = {v_zero, v_quadrature, v_direct, freq_step, lead_angle, grid_angle};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    a_commit_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> !m_axis_tvalid)
        else $error("result committed over an untaken word");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> m_axis_tvalid)
        else $error("committed result not presented");

    a_one_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.mul_en, cmd.wb_en, cmd.fold, cmd.rot_en, cmd.vq_en, cmd.fin}) <= 1)
        else $error("datapath given two commands at once");
`endif

endmodule

### tb/srf_pll_checker.sv
module srf_pll_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [199:0] m_axis_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           errors,
    output int           pending
);
    import srfpll_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // packed from the top bit down: grid_angle lands in the lowest bits
    typedef struct packed {
        logic [31:0] v_zero;
        logic [31:0] v_quadrature;
        logic [31:0] v_direct;
        logic [39:0] freq_step;
        logic [31:0] lead_angle;
        logic [31:0] grid_angle;
    } pll_result_t;

    localparam longint ATAN_TURNS [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam longint FREQ_HI = 64'sd549755813887;
    localparam longint FREQ_LO = -64'sd549755813888;

    // settings and loop state as the block should hold them
    logic [11:0]  ofs_a, ofs_b, ofs_c;
    logic [23:0]  gn_a, gn_b, gn_c;
    longint       kp_now, kp_prev;
    logic [31:0]  angle;
    longint       freq;
    longint       vq_prev;

    pll_result_t  pll_results_due [$];

    assign pending = pll_results_due.size();

    function automatic longint round_shift(longint x, int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint to_volts(logic [11:0] code, logic [11:0] ofs, logic [23:0] gn);
        longint d;
        d = longint'({52'd0, code}) - longint'({52'd0, ofs});
        return clip32(round_shift(d * longint'({40'd0, gn}), 8));
    endfunction

    task automatic pll_step(input logic [39:0] word, output pll_result_t r);
        longint va, vb, vc, alpha, beta, zero, x, y, z, xs, ys, vq, vd;
        longint p1, p2, hi, lo, nf;
        logic [31:0] turn;
        va = to_volts(word[11:0], ofs_a, gn_a);
        vb = to_volts(word[23:12], ofs_b, gn_b);
        vc = to_volts(word[35:24], ofs_c, gn_c);
        angle = angle + 32'(freq >>> 8);
        alpha = clip32(round_shift((2 * va - vb - vc) * 64'sd357913941, 30));
        beta  = clip32(round_shift((vb - vc) * 64'sd619925131, 30));
        zero  = clip32(round_shift((va + vb + vc) * 64'sd357913941, 30));
        x = round_shift(alpha * 64'sd652032874, 22);
        y = round_shift(beta * 64'sd652032874, 22);
        turn = angle;
        if (((turn + 32'h4000_0000) & 32'h8000_0000) != 0)
        begin
            x = -x;
            y = -y;
            turn = turn - 32'h8000_0000;
        end
        z = longint'(signed'(turn));
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z - ATAN_TURNS[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z + ATAN_TURNS[i];
            end
        end
        vq = clip32(round_shift(x, 8));
        vd = clip32(-round_shift(y, 8));
        // sum of both products rounded once: split high and low halves
        p1 = kp_now * vq;
        p2 = kp_prev * vq_prev;
        hi = (p1 >>> 16) + (p2 >>> 16);
        lo = longint'(p1 & 64'hFFFF) + longint'(p2 & 64'hFFFF);
        nf = freq + hi + ((lo + 32768) >>> 16);
        if (nf > FREQ_HI)
            nf = FREQ_HI;
        if (nf < FREQ_LO)
            nf = FREQ_LO;
        freq = nf;
        vq_prev = vq;
        r.grid_angle   = angle;
        r.lead_angle   = angle + 32'(freq >>> 9);
        r.freq_step    = 40'(freq);
        r.v_direct     = 32'(vd);
        r.v_quadrature = 32'(vq);
        r.v_zero       = 32'(zero);
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pll_result_t r, w;
        if (!rst_n)
        begin
            ofs_a   = OFFSET_A_RESET;
            ofs_b   = OFFSET_B_RESET;
            ofs_c   = OFFSET_C_RESET;
            gn_a    = GAIN_A_RESET;
            gn_b    = GAIN_B_RESET;
            gn_c    = GAIN_C_RESET;
            kp_now  = 64'sd4844136;
            kp_prev = -64'sd4839830;
            angle   = '0;
            freq    = 64'sd2748779069;
            vq_prev = 0;
            errors  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OFFSET_A:  ofs_a = cfg_data[11:0];
                    CFG_OFFSET_B:  ofs_b = cfg_data[11:0];
                    CFG_OFFSET_C:  ofs_c = cfg_data[11:0];
                    CFG_GAIN_A:    gn_a = cfg_data[23:0];
                    CFG_GAIN_B:    gn_b = cfg_data[23:0];
                    CFG_GAIN_C:    gn_c = cfg_data[23:0];
                    CFG_COEF_NOW:  kp_now = longint'(signed'(cfg_data));
                    CFG_COEF_PREV: kp_prev = longint'(signed'(cfg_data));
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                r = pll_result_t'(m_axis_tdata);
                if (pll_results_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected, got %0h", $time,
                             m_axis_tdata);
                end
                else
                begin
                    w = pll_results_due.pop_front();
                    check_field("grid_angle", w.grid_angle, r.grid_angle);
                    check_field("lead_angle", w.lead_angle, r.lead_angle);
                    check_field("freq_step", w.freq_step, r.freq_step);
                    check_field("v_direct", w.v_direct, r.v_direct);
                    check_field("v_quadrature", w.v_quadrature, r.v_quadrature);
                    check_field("v_zero", w.v_zero, r.v_zero);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pll_step(s_axis_tdata, w);
                pll_results_due.push_back(w);
            end
        end
    end

endmodule

### tb/testbench.sv
module testbench;
    import srfpll_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd201;
    localparam real TWO_PI = 6.283185307;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;   // code_a, code_b, code_c, zero padding
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // grid_angle, lead_angle, freq_step, v_direct, v_quadrature, v_zero
    logic [199:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [31:0]  cfg_data;
    int           errors;
    int           pending;
    int           burst_left;
    real          wave_ph;

    srf_pll_park_transform_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    srf_pll_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: modes of free flow, random stalls and a slow periodic accept
    always @(posedge clk or negedge rst_n)
    begin
        static int mode = 0;
        static int tick = 0;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            tick++;
            if (tick % 300 == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= (tick % 5 == 0);
            endcase
        end
    end

    task automatic send_codes(input logic [11:0] a, input logic [11:0] b, input logic [11:0] c);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 120);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, c, b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [11:0] oa, input logic [11:0] ob,
                                 input logic [11:0] oc, input logic [23:0] ga,
                                 input logic [23:0] gb, input logic [23:0] gc,
                                 input logic [31:0] kn, input logic [31:0] kpv);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        write_reg(CFG_OFFSET_A, {20'($urandom_range(0, 1048575)), oa});
        write_reg(CFG_OFFSET_B, {20'd0, ob});
        write_reg(CFG_OFFSET_C, {20'd0, oc});
        write_reg(CFG_GAIN_A, {8'hA5, ga});
        write_reg(CFG_GAIN_B, {8'd0, gb});
        write_reg(CFG_GAIN_C, {8'd0, gc});
        write_reg(CFG_COEF_NOW, kn);
        write_reg(CFG_COEF_PREV, kpv);
        write_reg(CFG_UNUSED, $urandom);
    endtask

    // mostly balanced three-phase waves at near-grid frequency, some raw noise
    task automatic random_items(input int count, input logic [11:0] mid);
        real amp, step;
        int ca, cb, cc;
        amp  = $urandom_range(0, 2047);
        step = TWO_PI / (400.0 + $urandom_range(0, 40) - 20.0);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_codes(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                           12'($urandom_range(0, 4095)));
            else
            begin
                wave_ph += step;
                ca = mid + $rtoi(amp * $sin(wave_ph)) + $urandom_range(0, 8) - 4;
                cb = mid + $rtoi(amp * $sin(wave_ph - TWO_PI / 3.0)) + $urandom_range(0, 8) - 4;
                cc = mid + $rtoi(amp * $sin(wave_ph + TWO_PI / 3.0)) + $urandom_range(0, 8) - 4;
                ca = ca < 0 ? 0 : (ca > 4095 ? 4095 : ca);
                cb = cb < 0 ? 0 : (cb > 4095 ? 4095 : cb);
                cc = cc < 0 ? 0 : (cc > 4095 ? 4095 : cc);
                send_codes(12'(ca), 12'(cb), 12'(cc));
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        clk           = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        burst_left    = 0;
        wave_ph       = 0.0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: code extremes, offsets exactly, alternating bit patterns
        send_codes(12'd0, 12'd0, 12'd0);
        send_codes(12'd4095, 12'd4095, 12'd4095);
        send_codes(12'd4095, 12'd0, 12'd0);
        send_codes(12'd0, 12'd4095, 12'd0);
        send_codes(12'd0, 12'd0, 12'd4095);
        send_codes(12'd2117, 12'd2090, 12'd2102);
        send_codes(12'hAAA, 12'h555, 12'hAAA);
        send_codes(12'h555, 12'hAAA, 12'h555);
        random_items(160, 12'd2100);

        // extremes: full gain, zero offsets, large loop weights drive freq to its limits
        load_settings(12'd0, 12'd0, 12'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                      32'h7FFF_FFFF, 32'h8000_0000);
        send_codes(12'd4095, 12'd0, 12'd0);
        send_codes(12'd0, 12'd4095, 12'd4095);
        send_codes(12'd4095, 12'd4095, 12'd4095);
        send_codes(12'd0, 12'd0, 12'd0);
        random_items(120, 12'd2048);

        load_settings(12'd4095, 12'd4095, 12'd4095, 24'd0, 24'd1, 24'hFFFFFF,
                      32'h8000_0000, 32'h7FFF_FFFF);
        send_codes(12'd0, 12'd0, 12'd0);
        send_codes(12'd4095, 12'd4095, 12'd4095);
        random_items(100, 12'd2048);

        load_settings(12'($urandom_range(1800, 2300)), 12'($urandom_range(1800, 2300)),
                      12'($urandom_range(1800, 2300)), 24'($urandom_range(2000000, 4000000)),
                      24'($urandom_range(2000000, 4000000)),
                      24'($urandom_range(2000000, 4000000)),
                      32'($urandom_range(0, 20000000)), 32'(-$urandom_range(0, 20000000)));
        random_items(130, 12'd2048);

        load_settings(12'd2117, 12'd2090, 12'd2102, 24'd2913199, 24'd2905378, 24'd2940244,
                      32'd4844136, -32'sd4839830);
        random_items(130, 12'd2100);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS srf_pll_park_transform_top");
        else
            $display("FAIL srf_pll_park_transform_top");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL srf_pll_park_transform_top");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/srfpll_pkg.sv
hw/rtl/srfpll_ctrl.sv
hw/rtl/srfpll_dp.sv
hw/rtl/srf_pll_park_transform_top.sv
tb/srf_pll_checker.sv
tb/testbench.sv
